// File: hw/rtl/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types, sizes and the 9-input median network of the 3x3 median filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mf3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int ADDR_W     = 3;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

  // register index, taken from paddr[2]
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef logic [23:0]      pix_t;
  typedef logic [COL_W-1:0] col_t;
  typedef logic [ROW_W-1:0] row_t;
  typedef logic [1:0]       sel_t;

  // line store write request
  typedef struct packed {
    logic en;
    col_t addr;
    pix_t upper;
    pix_t lower;
  } lb_wr_t;

  // compare-exchange pairs of the 19-step median-of-9 network
  localparam int MED_STEPS = 19;
  localparam int MED_A [MED_STEPS] =
    '{1, 4, 7, 0, 3, 6, 1, 4, 7, 0, 5, 4, 3, 1, 2, 4, 4, 6, 4};
  localparam int MED_B [MED_STEPS] =
    '{2, 5, 8, 1, 4, 7, 2, 5, 8, 3, 8, 7, 6, 4, 5, 7, 2, 4, 2};

  function automatic logic [7:0] med9(input logic [8:0][7:0] v);
    logic [8:0][7:0] p;
    logic [7:0]      t;
    p = v;
    for (int k = 0; k < MED_STEPS; k++) begin
      if (p[MED_A[k]] > p[MED_B[k]]) begin
        t            = p[MED_A[k]];
        p[MED_A[k]]  = p[MED_B[k]];
        p[MED_B[k]]  = t;
      end
    end
    return p[4];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mf3_line_buf.sv
// ----------------------------------------------------------------------------
// mf3_line_buf
// Two line stores (rows r-2 and r-1), registered read, one write per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mf3_line_buf (
  input  wire                  clk,
  input  wire                  rd_en,
  input  wire mf3_pkg::col_t   rd_addr,
  input  wire mf3_pkg::lb_wr_t wr,
  output mf3_pkg::pix_t        rd_top,
  output mf3_pkg::pix_t        rd_mid
);

  mf3_pkg::pix_t upper_mem [mf3_pkg::MAX_WIDTH];
  mf3_pkg::pix_t lower_mem [mf3_pkg::MAX_WIDTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      upper_mem[wr.addr] <= wr.upper;
      lower_mem[wr.addr] <= wr.lower;
    end
  end

  // registered read port (old data on same-address write)
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_top <= upper_mem[rd_addr];
      rd_mid <= lower_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mf3_median.sv
// ----------------------------------------------------------------------------
// mf3_median
// Per-channel median of nine 24-bit pixels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mf3_median (
  input  wire mf3_pkg::pix_t nbr [9],
  output logic [7:0]         med0,
  output logic [7:0]         med1,
  output logic [7:0]         med2
);

  logic [8:0][7:0] ch0, ch1, ch2;

  // split into channel planes
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      ch0[i] = nbr[i][7:0];
      ch1[i] = nbr[i][15:8];
      ch2[i] = nbr[i][23:16];
    end
  end

  assign med0 = mf3_pkg::med9(ch0);
  assign med1 = mf3_pkg::med9(ch1);
  assign med2 = mf3_pkg::med9(ch2);

endmodule

`default_nettype wire

// File: hw/rtl/median_filter_3x3.sv
// ----------------------------------------------------------------------------
// median_filter_3x3
// 3x3 per-channel median filter with mirrored borders over a raster stream.
// ----------------------------------------------------------------------------
// A pixel passes the stage 1 input register and stage 2 window; its result is then
// registered in the output register. Throughput: one pixel per cycle while each
// pixel gives at most one result and out_stall is low; a pixel giving more (end of
// row, last row) stalls the input while the single median unit sends all but the last.
// Reset: synchronous; counters, window and valids clear, registers 640 x 480.
// Line stores are not cleared; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module median_filter_3x3 (
  input  wire        clk,
  input  wire        rst,
  // config port
  input  wire        psel,
  input  wire        penable,
  input  wire        pwrite,
  input  wire [mf3_pkg::ADDR_W-1:0] paddr,
  input  wire [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // pixel input
  input  wire        in_valid,
  output logic       in_stall,
  input  wire [7:0]  chan0,
  input  wire [7:0]  chan1,
  input  wire [7:0]  chan2,
  // result output
  output logic       out_valid,
  input  wire        out_stall,
  output logic [mf3_pkg::COL_W-1:0] out_col,
  output logic [mf3_pkg::ROW_W-1:0] out_row,
  output logic [7:0] med0,
  output logic [7:0] med1,
  output logic [7:0] med2,
  output logic       run_last,
  output logic       frame_last
);

  // ---------------- configuration ----------------
  logic [mf3_pkg::WIDTH_W-1:0]  image_width;
  logic [mf3_pkg::HEIGHT_W-1:0] image_height;
  logic                         cfg_wr;
  mf3_pkg::col_t                w_m1;
  mf3_pkg::row_t                h_m1;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= mf3_pkg::WIDTH_RESET;
      image_height <= mf3_pkg::HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        mf3_pkg::REG_WIDTH:  image_width  <= pwdata[mf3_pkg::WIDTH_W-1:0];
        mf3_pkg::REG_HEIGHT: image_height <= pwdata[mf3_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      mf3_pkg::REG_WIDTH:  prdata = 32'(image_width);
      mf3_pkg::REG_HEIGHT: prdata = 32'(image_height);
      default:             prdata = '0;
    endcase
  end

  // last column / row index, with zero and oversize clamped
  always_comb begin
    if (image_width == '0)
      w_m1 = '0;
    else if (image_width > mf3_pkg::WIDTH_W'(mf3_pkg::MAX_WIDTH))
      w_m1 = mf3_pkg::col_t'(mf3_pkg::MAX_WIDTH - 1);
    else
      w_m1 = mf3_pkg::col_t'(image_width - 1'b1);
    if (image_height == '0)
      h_m1 = '0;
    else if (image_height > mf3_pkg::HEIGHT_W'(mf3_pkg::MAX_HEIGHT))
      h_m1 = mf3_pkg::row_t'(mf3_pkg::MAX_HEIGHT - 1);
    else
      h_m1 = mf3_pkg::row_t'(image_height - 1'b1);
  end

  // ---------------- stage 1: input register, line store read ----------------
  logic            in_xfer;
  logic            s1_valid;
  logic            s1_adv;
  logic            s2_take;
  mf3_pkg::pix_t   px1;
  mf3_pkg::col_t   c1;
  mf3_pkg::row_t   r1;
  logic            eor1, last1, byp1;
  mf3_pkg::pix_t   byp_top, byp_mid;
  mf3_pkg::pix_t   lb_top, lb_mid, top_eff, mid_eff;
  mf3_pkg::col_t   col_count;
  mf3_pkg::row_t   row_count;
  logic            eor_in, last_in;
  mf3_pkg::lb_wr_t lb_wr;

  assign s1_adv   = s1_valid && s2_take;
  assign in_stall = s1_valid && !s2_take;
  assign in_xfer  = in_valid && !in_stall;
  assign eor_in   = col_count >= w_m1;
  assign last_in  = row_count >= h_m1;

  // forward a write to the same column made at the read edge
  assign top_eff = byp1 ? byp_top : lb_top;
  assign mid_eff = byp1 ? byp_mid : lb_mid;

  assign lb_wr = '{en: s1_adv, addr: c1, upper: mid_eff, lower: px1};

  mf3_line_buf u_line_buf (
    .clk     (clk),
    .rd_en   (in_xfer),
    .rd_addr (col_count),
    .wr      (lb_wr),
    .rd_top  (lb_top),
    .rd_mid  (lb_mid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      col_count <= '0;
      row_count <= '0;
    end else begin
      if (in_xfer) s1_valid <= 1'b1;
      else if (s1_adv) s1_valid <= 1'b0;
      // raster position of the next pixel
      if (in_xfer) begin
        if (eor_in) begin
          col_count <= '0;
          row_count <= last_in ? '0 : row_count + 1'b1;
        end else begin
          col_count <= col_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      px1     <= {chan2, chan1, chan0};
      c1      <= col_count;
      r1      <= row_count;
      eor1    <= eor_in;
      last1   <= last_in;
      byp1    <= s1_adv && (c1 == col_count);
      byp_top <= mid_eff;
      byp_mid <= px1;
    end
  end

  // ---------------- stage 2: window and result sequencer ----------------
  mf3_pkg::pix_t window [3][3];   // [column oldest..newest][row top..bottom]
  logic [3:0]    pend;            // left/eor results of row above, then last row
  logic [3:0]    pick, rest;
  mf3_pkg::col_t c2;
  mf3_pkg::row_t r2;
  logic          eor2, last2;
  logic          out_free, adv3;
  logic          r_ge1, c_ge1;

  assign pick     = pend & (~pend + 4'd1);
  assign rest     = pend & ~pick;
  assign out_free = !out_valid || !out_stall;
  assign adv3     = (pend != 4'd0) && out_free;
  assign s2_take  = (pend == 4'd0) || (adv3 && (rest == 4'd0));
  assign r_ge1    = r1 != '0;
  assign c_ge1    = c1 != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          window[i][j] <= '0;
    end else if (s1_adv) begin
      pend <= {last1 && eor1, last1 && c_ge1, r_ge1 && eor1, r_ge1 && c_ge1};
      window[0] <= window[1];
      window[1] <= window[2];
      window[2] <= '{top_eff, mid_eff, px1};
    end else if (adv3) begin
      pend <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      c2    <= c1;
      r2    <= r1;
      eor2  <= eor1;
      last2 <= last1;
    end
  end

  // mirrored column and row selection for the chosen result
  logic          is_vr1, is_eor;
  mf3_pkg::sel_t csel [3];
  mf3_pkg::sel_t rsel [3];
  mf3_pkg::sel_t side, tb;
  mf3_pkg::pix_t nbr [9];
  logic [7:0]    m0, m1, m2;

  assign is_vr1 = pick[2] | pick[3];
  assign is_eor = pick[1] | pick[3];

  always_comb begin
    side = (c2 != '0) ? 2'd1 : 2'd2;
    tb   = (r2 != '0) ? 2'd1 : 2'd2;
    if (is_eor) begin
      csel[0] = side;
      csel[1] = 2'd2;
      csel[2] = side;
    end else begin
      csel[0] = (c2 == mf3_pkg::col_t'(1)) ? 2'd2 : 2'd0;
      csel[1] = 2'd1;
      csel[2] = 2'd2;
    end
    if (is_vr1) begin
      rsel[0] = tb;
      rsel[1] = 2'd2;
      rsel[2] = tb;
    end else begin
      rsel[0] = (r2 == mf3_pkg::row_t'(1)) ? 2'd2 : 2'd0;
      rsel[1] = 2'd1;
      rsel[2] = 2'd2;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        nbr[i*3 + j] = window[csel[j]][rsel[i]];
  end

  mf3_median u_median (
    .nbr  (nbr),
    .med0 (m0),
    .med1 (m1),
    .med2 (m2)
  );

  // ---------------- stage 3: output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv3) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      out_col    <= is_eor ? c2 : c2 - 1'b1;
      out_row    <= is_vr1 ? r2 : r2 - 1'b1;
      med0       <= m0;
      med1       <= m1;
      med2       <= m2;
      run_last   <= rest == 4'd0;
      frame_last <= (rest == 4'd0) && eor2 && last2;
    end
  end

  // ---------------- assertions ----------------
  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall) else $error("input stalled with empty stage");

  a_frame_last_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |-> run_last) else $error("frame end not run end");

  a_pend_order: assert property (@(posedge clk) disable iff (rst)
    adv3 && !s2_take |=> pend != 4'd0) else $error("pending results lost");

endmodule

`default_nettype wire
